### sv/sre_pkg.sv
// shared types, opcodes and sizes for the instruction executor
package sre_pkg;

    localparam int NUM_REGS   = 16;
    localparam int DATA_WORDS = 4096;
    localparam int REG_AW     = $clog2(NUM_REGS);
    localparam int MEM_AW     = $clog2(DATA_WORDS);
    localparam int CLR_W      = MEM_AW + 1;
    localparam int Q_DEPTH    = 2;
    localparam int Q_AW       = 1;

    localparam logic [15:0] INSN_BYTES = 16'd4;

    typedef enum logic [4:0] {
        OP_ADD   = 5'd0,
        OP_SUB   = 5'd1,
        OP_MUL   = 5'd2,
        OP_DIV   = 5'd3,
        OP_AND   = 5'd4,
        OP_OR    = 5'd5,
        OP_XOR   = 5'd6,
        OP_ADDL  = 5'd7,
        OP_SUBL  = 5'd8,
        OP_MOVC  = 5'd9,
        OP_LOAD  = 5'd10,
        OP_STORE = 5'd11,
        OP_CMP   = 5'd12,
        OP_CML   = 5'd13,
        OP_BZ    = 5'd14,
        OP_BNZ   = 5'd15,
        OP_JUMP  = 5'd16,
        OP_NOP   = 5'd17,
        OP_HALT  = 5'd18
    } op_t;

    // execution class chosen by the front end
    typedef enum logic [2:0] {
        CL_ALU,
        CL_DIV,
        CL_LOAD,
        CL_STORE,
        CL_CMP,
        CL_BRANCH,
        CL_OTHER
    } cls_t;

    // one classified instruction word in the queue
    typedef struct packed {
        cls_t                cls;
        op_t                 op;
        logic                use_lit;
        logic [REG_AW-1:0]   rd;
        logic [REG_AW-1:0]   rs1;
        logic [REG_AW-1:0]   rs2;
        logic [31:0]         lit;
        logic [15:0]         pc;
    } dec_t;

    // one result word
    typedef struct packed {
        logic                wen;
        logic [3:0]          widx;
        logic [31:0]         wval;
        logic                zero;
        logic                taken;
        logic [15:0]         npc;
        logic                halt;
        logic                derr;
    } res_t;

endpackage

### sv/simple_risc_instruction_executor.sv
// top level of the instruction executor
//
// queue-style channels on both sides. an instruction word is accepted on
// a clock edge with push high and full low. the result word is shown while
// empty is low and leaves on an edge with pop high.
// the front end classifies each word and holds up to two in a queue, so
// words can be pushed while the back end is busy or the receiver stalls.
// the back end runs one word at a time: queue take, register read, execute,
// then result. a load also passes through the data memory read port, and a
// divide with nonzero divisor waits on the bit-serial divider.
// the register write commits when the result is popped, so a stalled
// receiver holds the back end in place and the queue fills.
// after reset the data memory is swept to zero, one word a cycle, over all
// 4096 words; words are queued meanwhile but none executes. registers and
// the zero flag clear at once.
module simple_risc_instruction_executor (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [4:0]         operation,
    input  logic [3:0]         dest_reg,
    input  logic [3:0]         src1_reg,
    input  logic [3:0]         src2_reg,
    input  logic signed [31:0] literal,
    input  logic [15:0]        instr_pc,
    output logic               empty,
    input  logic               pop,
    output logic               reg_write_en,
    output logic [3:0]         reg_write_index,
    output logic signed [31:0] reg_write_value,
    output logic               zero_now,
    output logic               branch_taken,
    output logic [15:0]        next_pc,
    output logic               halted,
    output logic               div_error
);

    logic          q_valid, q_take;
    sre_pkg::dec_t q_word;
    sre_pkg::res_t res;

    sre_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .operation (operation),
        .dest_reg  (dest_reg),
        .src1_reg  (src1_reg),
        .src2_reg  (src2_reg),
        .literal   (literal),
        .instr_pc  (instr_pc),
        .q_valid   (q_valid),
        .q_take    (q_take),
        .q_word    (q_word)
    );

    sre_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_take  (q_take),
        .q_word  (q_word),
        .empty   (empty),
        .pop     (pop),
        .res     (res)
    );

    assign reg_write_en    = res.wen;
    assign reg_write_index = res.widx;
    assign reg_write_value = res.wval;
    assign zero_now        = res.zero;
    assign branch_taken    = res.taken;
    assign next_pc         = res.npc;
    assign halted          = res.halt;
    assign div_error       = res.derr;

endmodule

### sv/sre_front.sv
// front end: accepts instruction words, classifies them, queues them for execution
module sre_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  logic [4:0]    operation,
    input  logic [3:0]    dest_reg,
    input  logic [3:0]    src1_reg,
    input  logic [3:0]    src2_reg,
    input  logic signed [31:0] literal,
    input  logic [15:0]   instr_pc,
    output logic          q_valid,
    input  logic          q_take,
    output sre_pkg::dec_t q_word
);

    sre_pkg::dec_t                  mem_reg [sre_pkg::Q_DEPTH];
    logic [sre_pkg::Q_AW-1:0]       wptr_reg, rptr_reg;
    logic [sre_pkg::Q_AW:0]         cnt_reg;
    sre_pkg::dec_t                  dec;
    logic                           do_push, do_pop;

    // classify the incoming opcode
    always_comb
    begin
        dec.op      = sre_pkg::op_t'(operation);
        dec.rd      = sre_pkg::REG_AW'(dest_reg);
        dec.rs1     = sre_pkg::REG_AW'(src1_reg);
        dec.rs2     = sre_pkg::REG_AW'(src2_reg);
        dec.lit     = literal;
        dec.pc      = instr_pc;
        dec.use_lit = 1'b0;
        dec.cls     = sre_pkg::CL_OTHER;
        unique case (operation)
            sre_pkg::OP_ADD, sre_pkg::OP_SUB, sre_pkg::OP_MUL, sre_pkg::OP_AND,
            sre_pkg::OP_OR, sre_pkg::OP_XOR:
                dec.cls = sre_pkg::CL_ALU;
            sre_pkg::OP_ADDL, sre_pkg::OP_SUBL, sre_pkg::OP_MOVC:
            begin
                dec.cls     = sre_pkg::CL_ALU;
                dec.use_lit = 1'b1;
            end
            sre_pkg::OP_DIV:   dec.cls = sre_pkg::CL_DIV;
            sre_pkg::OP_LOAD:  dec.cls = sre_pkg::CL_LOAD;
            sre_pkg::OP_STORE: dec.cls = sre_pkg::CL_STORE;
            sre_pkg::OP_CMP:   dec.cls = sre_pkg::CL_CMP;
            sre_pkg::OP_CML:
            begin
                dec.cls     = sre_pkg::CL_CMP;
                dec.use_lit = 1'b1;
            end
            sre_pkg::OP_BZ, sre_pkg::OP_BNZ, sre_pkg::OP_JUMP:
                dec.cls = sre_pkg::CL_BRANCH;
            sre_pkg::OP_HALT:  dec.cls = sre_pkg::CL_OTHER;
            default:
            begin
                dec.cls = sre_pkg::CL_OTHER;
                dec.op  = sre_pkg::OP_NOP;
            end
        endcase
    end

    assign full    = (cnt_reg == (sre_pkg::Q_AW+1)'(sre_pkg::Q_DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_word  = mem_reg[rptr_reg];
    assign do_push = push && !full;
    assign do_pop  = q_take && q_valid;

    // queue storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wptr_reg] <= dec;
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wptr_reg <= wptr_reg + 1'b1;
            if (do_pop)
                rptr_reg <= rptr_reg + 1'b1;
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (!do_push && do_pop)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> cnt_reg == (sre_pkg::Q_AW+1)'(sre_pkg::Q_DEPTH))
        else $error("queue count beyond depth");
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (sre_pkg::Q_AW+1)'(sre_pkg::Q_DEPTH))
        else $error("queue count out of range");
    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("push lost");
`endif

endmodule

### sv/sre_div.sv
// iterative signed divider, one quotient bit per cycle
module sre_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);

    logic [31:0] rem_reg, quo_reg, dvs_reg;
    logic [5:0]  cnt_reg;
    logic        neg_reg, busy_reg, done_reg;
    logic [32:0] trial;
    logic [31:0] shifted;

    assign shifted  = {rem_reg[30:0], quo_reg[31]};
    assign trial    = {1'b0, shifted} - {1'b0, dvs_reg};
    assign done     = done_reg;
    assign quotient = neg_reg ? (32'd0 - quo_reg) : quo_reg;

    // restoring division over magnitudes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd32;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend[31] ? (32'd0 - dividend) : dividend;
            dvs_reg <= divisor[31] ? (32'd0 - divisor) : divisor;
            neg_reg <= dividend[31] ^ divisor[31];
        end
        else if (busy_reg)
        begin
            if (!trial[32])
            begin
                rem_reg <= trial[31:0];
                quo_reg <= {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
        end
    end

endmodule

### sv/sre_back.sv
// back end: register file, data memory, zero flag and execution sequencer
module sre_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    output logic          q_take,
    input  sre_pkg::dec_t q_word,
    output logic          empty,
    input  logic          pop,
    output sre_pkg::res_t res
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EXEC,
        S_DIV,
        S_MEM,
        S_OUT
    } state_t;

    state_t                       state_reg;
    logic [31:0]                  rf_reg [sre_pkg::NUM_REGS];
    logic [31:0]                  dmem [sre_pkg::DATA_WORDS];
    logic [31:0]                  mem_rd_reg;
    logic                         zero_reg;
    logic                         zero_next;
    logic [sre_pkg::CLR_W-1:0]    clr_reg;
    sre_pkg::dec_t                cur_reg;
    logic [31:0]                  v1_reg, v2_reg;
    logic [31:0]                  alu_reg;
    sre_pkg::res_t                res_reg;
    sre_pkg::res_t                res_next;
    logic                         div_start, div_done;
    logic [31:0]                  div_q;
    logic [31:0]                  opb;
    logic [31:0]                  alu;
    logic [31:0]                  addr;
    logic                         mem_we;
    logic [sre_pkg::MEM_AW-1:0]   mem_wa;
    logic [31:0]                  mem_wd;
    logic                         rf_we;
    logic [31:0]                  rf_wd;

    sre_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (v1_reg),
        .divisor  (v2_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign empty     = (state_reg != S_OUT);
    assign res       = res_reg;
    assign q_take    = (state_reg == S_IDLE) && q_valid;
    assign div_start = (state_reg == S_EXEC) && (cur_reg.cls == sre_pkg::CL_DIV)
                       && (v2_reg != '0);
    assign opb       = cur_reg.use_lit ? cur_reg.lit : v2_reg;
    assign addr      = (cur_reg.cls == sre_pkg::CL_STORE) ? (v2_reg + cur_reg.lit)
                                                          : (v1_reg + cur_reg.lit);

    // alu
    always_comb
    begin
        case (cur_reg.op)
            sre_pkg::OP_ADD, sre_pkg::OP_ADDL: alu = v1_reg + opb;
            sre_pkg::OP_SUB, sre_pkg::OP_SUBL: alu = v1_reg - opb;
            sre_pkg::OP_MUL:  alu = v1_reg * v2_reg;
            sre_pkg::OP_AND:  alu = v1_reg & v2_reg;
            sre_pkg::OP_OR:   alu = v1_reg | v2_reg;
            sre_pkg::OP_XOR:  alu = v1_reg ^ v2_reg;
            sre_pkg::OP_MOVC: alu = cur_reg.lit;
            default:          alu = '0;
        endcase
    end

    // memory write selection: clearing sweep or store
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = addr[sre_pkg::MEM_AW-1:0];
        mem_wd = v1_reg;
        if (state_reg == S_CLEAR)
        begin
            mem_we = 1'b1;
            mem_wa = clr_reg[sre_pkg::MEM_AW-1:0];
            mem_wd = '0;
        end
        else if (state_reg == S_EXEC && cur_reg.cls == sre_pkg::CL_STORE)
            mem_we = 1'b1;
    end

    // data memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
            dmem[mem_wa] <= mem_wd;
        mem_rd_reg <= dmem[addr[sre_pkg::MEM_AW-1:0]];
    end

    // register file write
    always_comb
    begin
        rf_we = 1'b0;
        rf_wd = alu_reg;
        if (state_reg == S_OUT && pop && res_reg.wen)
        begin
            rf_we = 1'b1;
            rf_wd = res_reg.wval;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < sre_pkg::NUM_REGS; i++)
                rf_reg[i] <= '0;
        end
        else if (rf_we)
            rf_reg[res_reg.widx[sre_pkg::REG_AW-1:0]] <= rf_wd;
    end

    // next result word and zero flag
    always_comb
    begin
        res_next  = res_reg;
        zero_next = zero_reg;
        unique case (state_reg)
            S_EXEC:
            begin
                res_next      = '0;
                res_next.zero = zero_reg;
                res_next.npc  = cur_reg.pc + sre_pkg::INSN_BYTES;
                unique case (cur_reg.cls)
                    sre_pkg::CL_ALU:
                    begin
                        res_next.wen  = 1'b1;
                        res_next.widx = 4'(cur_reg.rd);
                        res_next.wval = alu;
                        res_next.zero = (alu == '0);
                        zero_next     = (alu == '0);
                    end
                    sre_pkg::CL_DIV:
                    begin
                        res_next.wen  = 1'b1;
                        res_next.widx = 4'(cur_reg.rd);
                        if (v2_reg == '0)
                        begin
                            res_next.zero = 1'b1;
                            res_next.derr = 1'b1;
                            zero_next     = 1'b1;
                        end
                    end
                    sre_pkg::CL_LOAD:
                    begin
                        res_next.wen  = 1'b1;
                        res_next.widx = 4'(cur_reg.rd);
                    end
                    sre_pkg::CL_CMP:
                    begin
                        res_next.zero = (v1_reg == opb);
                        zero_next     = (v1_reg == opb);
                    end
                    sre_pkg::CL_BRANCH:
                    begin
                        if ((cur_reg.op == sre_pkg::OP_JUMP)
                            || (cur_reg.op == sre_pkg::OP_BZ && zero_reg)
                            || (cur_reg.op == sre_pkg::OP_BNZ && !zero_reg))
                        begin
                            res_next.taken = 1'b1;
                            res_next.npc   = cur_reg.pc + cur_reg.lit[15:0];
                        end
                    end
                    default:
                        res_next.halt = (cur_reg.op == sre_pkg::OP_HALT);
                endcase
            end
            S_DIV:
                if (div_done)
                begin
                    res_next.wval = div_q;
                    res_next.zero = (div_q == '0);
                    zero_next     = (div_q == '0);
                end
            S_MEM:
                res_next.wval = mem_rd_reg;
            default: ;
        endcase
    end

    // sequencer with registered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            zero_reg  <= 1'b0;
            res_reg   <= '0;
        end
        else
        begin
            res_reg  <= res_next;
            zero_reg <= zero_next;
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == sre_pkg::CLR_W'(sre_pkg::DATA_WORDS - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                    if (q_valid)
                        state_reg <= S_READ;
                S_READ:
                    state_reg <= S_EXEC;
                S_EXEC:
                    if (div_start)
                        state_reg <= S_DIV;
                    else if (cur_reg.cls == sre_pkg::CL_LOAD)
                        state_reg <= S_MEM;
                    else
                        state_reg <= S_OUT;
                S_DIV:
                    if (div_done)
                        state_reg <= S_OUT;
                S_MEM:
                    state_reg <= S_OUT;
                S_OUT:
                    if (pop)
                        state_reg <= S_IDLE;
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // operand capture
    always_ff @(posedge clk)
    begin
        if (q_take)
            cur_reg <= q_word;
        if (state_reg == S_READ)
        begin
            v1_reg <= rf_reg[cur_reg.rs1];
            v2_reg <= rf_reg[cur_reg.rs2];
        end
        alu_reg <= alu;
    end

`ifndef ASSERT_OFF
    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_take |=> state_reg == S_READ)
        else $error("taken word not read");
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && !pop) |=> $stable(res_reg) && state_reg == S_OUT)
        else $error("result changed while waiting");
    a_no_take_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLEAR |-> !q_take)
        else $error("word taken during clear");
    a_derr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && res_reg.derr) |-> res_reg.zero && res_reg.wval == '0)
        else $error("divide error result wrong");
`endif

endmodule
